>>> design/key_sequence_prefix_matcher_defines.svh
// Assertion macros shared by the key sequence prefix matcher.
`ifndef KEY_SEQUENCE_PREFIX_MATCHER_DEFINES_SVH
`define KEY_SEQUENCE_PREFIX_MATCHER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksp: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define KSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksp: next-cycle check failed");

`endif

>>> design/ksp_pkg.sv
package ksp_pkg;

    // Default table geometry.
    localparam int NumEntriesDef = 16;
    localparam int MaxSeqLenDef  = 8;
    localparam int MaxEventsDef  = 8;

    // Input item kinds, carried on tuser.
    typedef enum logic [2:0] {
        KIND_KEY      = 3'd0,
        KIND_PAT_BYTE = 3'd1,
        KIND_EVT_CODE = 3'd2,
        KIND_PAT_LEN  = 3'd3,
        KIND_EVT_CNT  = 3'd4
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_ADVANCE = 2'd0,
        STAT_MATCH   = 2'd1,
        STAT_NOMATCH = 2'd2,
        STAT_LOADED  = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVT_RD,
        S_EVT_PUT,
        S_RESP
    } t_state;

    // Address width of a store with the given depth, at least one bit.
    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> design/key_sequence_prefix_matcher.sv
// Key sequence prefix matcher.
// The slave stream carries one item per transfer: tuser holds the kind (key byte or
// one of four table load kinds) and tdata holds key, entry, position and value. The
// master stream returns results: one per load or per key that advances or misses, and
// one per event code when a key completes a table entry, or a single one when it has
// none (tlast on the final one). A key is checked against one table entry per cycle
// through the single pattern memory read port. Each event code of a match is then
// fetched by one event memory read and placed by one output register load.
// The slave side takes one item at a time; tready is high only while the sequencer
// idles, and a finished result may still wait in the output register meanwhile.
// When the receiver stalls, the sequencer holds its pending result until the output
// register frees. Reset clears the depth, the candidate bits, all pattern lengths and
// event counts and empties the output register, and tready stays low while reset is
// held; pattern bytes and event codes are undefined until loaded. Kinds five to seven
// are taken and produce no result.
`include "key_sequence_prefix_matcher_defines.svh"

module key_sequence_prefix_matcher #(
    parameter int NUM_ENTRIES = ksp_pkg::NumEntriesDef,
    parameter int MAX_SEQ_LEN = ksp_pkg::MaxSeqLenDef,
    parameter int MAX_EVENTS  = ksp_pkg::MaxEventsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key[7:0], entry[11:8], position[14:12], value[24:15], zero fill[31:25]
    input  logic [31:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], has_event[2], event_code[12:3], matched_entry[16:13], zero fill[23:17]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int ENT_W  = ksp_pkg::addr_width(NUM_ENTRIES);
    localparam int IDX_W  = ENT_W + 1;
    localparam int DEP_W  = ksp_pkg::addr_width(MAX_SEQ_LEN);
    localparam int LEN_W  = $clog2(MAX_SEQ_LEN + 1);
    localparam int EVI_W  = ksp_pkg::addr_width(MAX_EVENTS);
    localparam int EVC_W  = $clog2(MAX_EVENTS + 1);
    localparam int PAT_AW = ksp_pkg::addr_width(NUM_ENTRIES * MAX_SEQ_LEN);
    localparam int EVT_AW = ksp_pkg::addr_width(NUM_ENTRIES * MAX_EVENTS);

    // Input fields.
    logic [7:0]     w_key;
    logic [3:0]     w_entry;
    logic [2:0]     w_position;
    logic [9:0]     w_value;
    ksp_pkg::t_kind w_kind;
    logic           w_in_xfer;
    logic           w_ent_ok;
    logic [ENT_W-1:0] w_ent_idx;

    assign w_key      = s_axis_tdata[7:0];
    assign w_entry    = s_axis_tdata[11:8];
    assign w_position = s_axis_tdata[14:12];
    assign w_value    = s_axis_tdata[24:15];
    assign w_kind     = ksp_pkg::t_kind'(s_axis_tuser);
    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_ent_ok   = 32'(w_entry) < NUM_ENTRIES;
    assign w_ent_idx  = ENT_W'(w_entry);

    // Sequencer and table state.
    ksp_pkg::t_state  r_state, n_state;
    logic [DEP_W-1:0] r_depth;
    logic [NUM_ENTRIES-1:0] r_cand;
    logic [LEN_W-1:0] r_len [NUM_ENTRIES];
    logic [EVC_W-1:0] r_cnt [NUM_ENTRIES];
    logic [7:0]       r_key;
    logic [IDX_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic [ENT_W-1:0] r_cmp_idx;
    logic             r_surv;
    logic [ENT_W-1:0] r_hit;
    logic [EVC_W-1:0] r_ev_idx;
    logic [EVC_W-1:0] r_ev_n;
    ksp_pkg::t_status r_res_status;
    logic [3:0]       r_res_entry;
    logic [7:0]       r_pat_rd;
    logic [9:0]       r_ev_rd;

    // Output register.
    logic             r_out_vld;
    ksp_pkg::t_status r_out_status;
    logic             r_out_has;
    logic [9:0]       r_out_code;
    logic [3:0]       r_out_entry;
    logic             r_out_last;

    // Memories for pattern bytes and event codes.
    logic [7:0] r_pat_mem [NUM_ENTRIES * MAX_SEQ_LEN];
    logic [9:0] r_evt_mem [NUM_ENTRIES * MAX_EVENTS];

    // Shared compare unit: one table entry per cycle.
    logic [LEN_W-1:0] w_cmp_len;
    logic             w_cmp_hit;
    logic             w_cmp_full;
    logic             w_cmp_last;
    logic             w_issue;
    logic             w_out_free;
    logic             w_ev_last;

    assign w_cmp_len  = r_len[r_cmp_idx];
    assign w_cmp_hit  = r_cmp_vld && r_cand[r_cmp_idx] && (w_cmp_len > LEN_W'(r_depth))
                        && (r_pat_rd == r_key);
    assign w_cmp_full = w_cmp_hit && (w_cmp_len == LEN_W'(r_depth) + LEN_W'(1));
    assign w_cmp_last = r_cmp_vld && (r_cmp_idx == ENT_W'(NUM_ENTRIES - 1));
    assign w_issue    = r_idx < IDX_W'(NUM_ENTRIES);
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_ev_last  = (r_ev_idx + EVC_W'(1)) == r_ev_n;

    // Memory addresses.
    logic [PAT_AW-1:0] w_pat_wa, w_pat_ra;
    logic [EVT_AW-1:0] w_evt_wa, w_evt_ra;

    assign w_pat_wa = PAT_AW'(w_ent_idx) * PAT_AW'(MAX_SEQ_LEN) + PAT_AW'(w_position);
    assign w_pat_ra = PAT_AW'(r_idx[ENT_W-1:0]) * PAT_AW'(MAX_SEQ_LEN) + PAT_AW'(r_depth);
    assign w_evt_wa = EVT_AW'(w_ent_idx) * EVT_AW'(MAX_EVENTS) + EVT_AW'(w_position);
    assign w_evt_ra = EVT_AW'(r_hit) * EVT_AW'(MAX_EVENTS) + EVT_AW'(r_ev_idx[EVI_W-1:0]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ksp_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    case (w_kind) inside
                        ksp_pkg::KIND_KEY: n_state = ksp_pkg::S_SCAN;
                        ksp_pkg::KIND_PAT_BYTE, ksp_pkg::KIND_EVT_CODE,
                        ksp_pkg::KIND_PAT_LEN, ksp_pkg::KIND_EVT_CNT: begin
                            n_state = ksp_pkg::S_RESP;
                        end
                        default: n_state = ksp_pkg::S_IDLE;
                    endcase
                end
            end
            ksp_pkg::S_SCAN: begin
                if (w_cmp_full) begin
                    n_state = (r_cnt[r_cmp_idx] == '0) ? ksp_pkg::S_RESP : ksp_pkg::S_EVT_RD;
                end else if (w_cmp_last) begin
                    n_state = ksp_pkg::S_RESP;
                end
            end
            ksp_pkg::S_EVT_RD: n_state = ksp_pkg::S_EVT_PUT;
            ksp_pkg::S_EVT_PUT: begin
                if (w_out_free) begin
                    n_state = w_ev_last ? ksp_pkg::S_IDLE : ksp_pkg::S_EVT_RD;
                end
            end
            ksp_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_state = ksp_pkg::S_IDLE;
                end
            end
            default: n_state = ksp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    logic             w_out_load;
    logic             n_cmp_vld;
    ksp_pkg::t_status w_ld_status;
    logic             w_ld_has;
    logic [9:0]       w_ld_code;
    logic [3:0]       w_ld_entry;
    logic             w_ld_last;

    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        n_cmp_vld     = 1'b0;
        w_ld_status   = r_res_status;
        w_ld_has      = 1'b0;
        w_ld_code     = '0;
        w_ld_entry    = r_res_entry;
        w_ld_last     = 1'b1;
        unique case (r_state)
            ksp_pkg::S_IDLE: s_axis_tready = i_rst_n;
            ksp_pkg::S_SCAN: n_cmp_vld = w_issue && (n_state == ksp_pkg::S_SCAN);
            ksp_pkg::S_EVT_RD: ;
            ksp_pkg::S_EVT_PUT: begin
                w_out_load  = w_out_free;
                w_ld_status = ksp_pkg::STAT_MATCH;
                w_ld_has    = 1'b1;
                w_ld_code   = r_ev_rd;
                w_ld_entry  = 4'(r_hit);
                w_ld_last   = w_ev_last;
            end
            ksp_pkg::S_RESP: w_out_load = w_out_free;
            default: ;
        endcase
    end

    // Control state and the length and count tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ksp_pkg::S_IDLE;
            r_depth   <= '0;
            r_cand    <= '0;
            r_cmp_vld <= 1'b0;
            r_surv    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_len[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            // Item transfer: arm the scan or write a table register.
            if (w_in_xfer) begin
                case (w_kind)
                    ksp_pkg::KIND_KEY: begin
                        r_surv <= 1'b0;
                        if (r_depth == '0) begin
                            r_cand <= '1;
                        end
                    end
                    ksp_pkg::KIND_PAT_LEN: begin
                        if (w_ent_ok) begin
                            r_len[w_ent_idx] <= (32'(w_value) > MAX_SEQ_LEN) ?
                                LEN_W'(MAX_SEQ_LEN) : LEN_W'(w_value);
                        end
                    end
                    ksp_pkg::KIND_EVT_CNT: begin
                        if (w_ent_ok) begin
                            r_cnt[w_ent_idx] <= (32'(w_value) > MAX_EVENTS) ?
                                EVC_W'(MAX_EVENTS) : EVC_W'(w_value);
                        end
                    end
                    default: ;
                endcase
            end
            // Scan: drop failing candidates and settle the depth at the end.
            if (r_state == ksp_pkg::S_SCAN) begin
                if (r_cmp_vld && !w_cmp_hit) begin
                    r_cand[r_cmp_idx] <= 1'b0;
                end
                if (w_cmp_hit) begin
                    r_surv <= 1'b1;
                end
                if (w_cmp_full) begin
                    r_depth <= '0;
                end else if (w_cmp_last) begin
                    r_depth <= (r_surv || w_cmp_hit) ? r_depth + DEP_W'(1) : '0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_key        <= w_key;
            r_idx        <= '0;
            r_res_status <= ksp_pkg::STAT_LOADED;
            r_res_entry  <= '0;
        end
        if (r_state == ksp_pkg::S_SCAN) begin
            if (w_issue) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_cmp_idx <= r_idx[ENT_W-1:0];
            if (w_cmp_full) begin
                r_hit        <= r_cmp_idx;
                r_ev_n       <= r_cnt[r_cmp_idx];
                r_ev_idx     <= '0;
                r_res_status <= ksp_pkg::STAT_MATCH;
                r_res_entry  <= 4'(r_cmp_idx);
            end else if (w_cmp_last) begin
                r_res_status <= (r_surv || w_cmp_hit) ? ksp_pkg::STAT_ADVANCE :
                                                        ksp_pkg::STAT_NOMATCH;
                r_res_entry  <= '0;
            end
        end
        if (r_state == ksp_pkg::S_EVT_PUT && w_out_free && !w_ev_last) begin
            r_ev_idx <= r_ev_idx + EVC_W'(1);
        end
        if (w_out_load) begin
            r_out_status <= w_ld_status;
            r_out_has    <= w_ld_has;
            r_out_code   <= w_ld_code;
            r_out_entry  <= w_ld_entry;
            r_out_last   <= w_ld_last;
        end
    end

    // Pattern byte memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_kind == ksp_pkg::KIND_PAT_BYTE && w_ent_ok
                && 32'(w_position) < MAX_SEQ_LEN) begin
            r_pat_mem[w_pat_wa] <= w_value[7:0];
        end
        r_pat_rd <= r_pat_mem[w_pat_ra];
    end

    // Event code memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_kind == ksp_pkg::KIND_EVT_CODE && w_ent_ok
                && 32'(w_position) < MAX_EVENTS) begin
            r_evt_mem[w_evt_wa] <= w_value;
        end
        r_ev_rd <= r_evt_mem[w_evt_ra];
    end

    // Result stream.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out_entry, r_out_code, r_out_has, r_out_status};
    assign m_axis_tlast  = r_out_last;

    // Checks on the sequencer.
    `KSP_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, 32'(r_depth) < MAX_SEQ_LEN)
    `KSP_ASSERT_IMP(a_cmp_in_scan, i_clk, i_rst_n, r_cmp_vld, r_state == ksp_pkg::S_SCAN)
    `KSP_ASSERT_IMP(a_evt_in_range, i_clk, i_rst_n, r_state == ksp_pkg::S_EVT_PUT, r_ev_idx < r_ev_n)
    `KSP_ASSERT_NXT(a_load_resp, i_clk, i_rst_n, w_in_xfer && w_kind == ksp_pkg::KIND_PAT_LEN, r_state == ksp_pkg::S_RESP)

endmodule
